FILE: hdl/repd_pkg.sv
// ----------------------------------------------------------------------------
// repd_pkg
// Shared types and constants for the rumble envelope pulse driver.
// ----------------------------------------------------------------------------
package repd_pkg;

  localparam int unsigned RetryTicks = 60;
  localparam int unsigned RetryW     = $clog2(RetryTicks);
  localparam logic [19:0] MinLeft    = 20'd6554;

  // raw opcodes on the input port
  localparam logic [1:0] OP_TIME = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_REQ  = 2'd2;

  // classified command kinds
  typedef enum logic [1:0] {
    K_NOP  = 2'd0,
    K_TIME = 2'd1,
    K_TICK = 2'd2,
    K_REQ  = 2'd3
  } kind_e;

  // motor drive commands
  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_START = 2'd1,
    DRV_STOP  = 2'd2
  } drive_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] delta_time;
    logic [16:0] start_strength;
    logic [16:0] end_strength;
    logic [19:0] duration;
    logic        init_ok;
    logic        drive_ok;
  } cmd_t;

  typedef struct packed {
    logic   init_cmd;
    drive_e drive_cmd;
    logic   motor_level;
    logic   motor_ready;
  } res_t;

endpackage

FILE: hdl/rumble_envelope_pulse_driver_unit.sv
// ----------------------------------------------------------------------------
// rumble_envelope_pulse_driver_unit
// Pulse driver for an on/off vibration motor following a linear envelope.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats enter through push/full: one beat is taken at each clock edge
//   with push high and full low. A two-entry command queue sits in front of
//   the execution unit, so up to two beats are taken while it is busy.
//   Each beat yields one result beat, read through empty/pop: the oldest
//   result is on the ports while empty is low and leaves on pop.
//   pak_present is written through cfg_valid/cfg_ready (always ready); the user
//   must write it only while the block is idle, which the block does not enforce.
//   Time items, requests and no-ops finish in the execution unit's idle state;
//   a frame tick runs through multiply, clamp, four divide steps for the pulse
//   period and finish, and no new command is taken until the tick is done.
//   A result is readable the cycle after it is queued.
//   Reset clears all envelope, counter and link state and empties both
//   queues. When the reader stalls, the two-entry result queue fills, the
//   execution unit holds, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module rumble_envelope_pulse_driver_unit import repd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] delta_time_i,
  input  logic [16:0] start_strength_i,
  input  logic [16:0] end_strength_i,
  input  logic [19:0] duration_i,
  input  logic        suppress_i,
  input  logic        init_ok_i,
  input  logic        drive_ok_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic        init_cmd_o,
  output logic [1:0]  drive_cmd_o,
  output logic        motor_level_o,
  output logic        motor_ready_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  // front: classify and queue
  repd_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .opcode_i, .delta_time_i, .start_strength_i, .end_strength_i,
    .duration_i, .suppress_i, .init_ok_i, .drive_ok_i,
    .cfg_valid, .cfg_data_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: execute and queue results
  repd_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty, .pop,
    .res_o       (res)
  );

  assign init_cmd_o    = res.init_cmd;
  assign drive_cmd_o   = res.drive_cmd;
  assign motor_level_o = res.motor_level;
  assign motor_ready_o = res.motor_ready;

endmodule

FILE: hdl/repd_front.sv
// ----------------------------------------------------------------------------
// repd_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module repd_front import repd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] delta_time_i,
  input  logic [16:0] start_strength_i,
  input  logic [16:0] end_strength_i,
  input  logic [19:0] duration_i,
  input  logic        suppress_i,
  input  logic        init_ok_i,
  input  logic        drive_ok_i,
  input  logic        cfg_valid,
  input  logic        cfg_data_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  logic       pak_q;
  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       do_push, do_pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pak_q <= 1'b0;
    end else if (cfg_valid) begin
      pak_q <= cfg_data_i;
    end
  end

  // classify: ignored items become no-ops
  always_comb begin
    cls.delta_time     = delta_time_i;
    cls.start_strength = start_strength_i;
    cls.end_strength   = end_strength_i;
    cls.duration       = duration_i;
    cls.init_ok        = init_ok_i;
    cls.drive_ok       = drive_ok_i;
    unique case (opcode_i)
      OP_TIME: cls.kind = pak_q ? K_TIME : K_NOP;
      OP_TICK: cls.kind = K_TICK;
      OP_REQ:  cls.kind = (pak_q && !suppress_i && duration_i != '0) ? K_REQ : K_NOP;
      default: cls.kind = K_NOP;
    endcase
  end

  assign full        = cnt_q == 2'd2;
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cnt_q != 2'd0;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rd_q];

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cls;
  end

endmodule

FILE: hdl/repd_back.sv
// ----------------------------------------------------------------------------
// repd_back
// Executes classified commands against the envelope and motor state and
// queues one result beat per command.
// ----------------------------------------------------------------------------
module repd_back import repd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_valid_i,
  input  cmd_t   cmd_i,
  output logic   cmd_pop_o,
  output logic   empty,
  input  logic   pop,
  output res_t   res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUB, S_DIV, S_FIN
  } state_e;

  state_e        state_q;
  logic [31:0]   fc_q;
  logic [RetryW-1:0] r60_q;
  logic [3:0]    rmod_q [2:9];
  logic          level_q, ready_q;
  logic [19:0]   dur_q, el_q;
  logic [16:0]   st_q, en_q;
  logic          init_q, zero_q, dok_q;
  logic signed [39:0] pa_q, pb_q;
  logic [19:0]   d_q;
  logic [36:0]   rem_q;
  logic [3:0]    quo_q;
  logic [1:0]    bit_q;

  res_t          rmem_q [2];
  logic          rwr_q, rrd_q;
  logic [1:0]    rcnt_q;
  logic          rpush;
  res_t          rdat;

  logic [20:0]   tsum;
  logic [19:0]   left;
  logic          keep;
  logic          wrap;
  logic [19:0]   dsel, esel;
  logic signed [18:0] wa, wdiff;
  logic signed [40:0] num;
  logic [36:0]   full_v, trial;
  logic [3:0]    per;
  logic          lvl;

  // combinational helpers
  always_comb begin
    tsum   = {1'b0, el_q} + {5'b0, cmd_i.delta_time};
    left   = (dur_q >= el_q) ? dur_q - el_q : '0;
    keep   = (left >= MinLeft) &&
             ({1'b0, cmd_i.start_strength} + {1'b0, cmd_i.end_strength} <
              {1'b0, st_q} + {1'b0, en_q});
    wrap   = fc_q == '1;
    dsel   = (dur_q == '0) ? 20'd1 : dur_q;
    esel   = (dur_q == '0) ? 20'd0 : el_q;
    wa     = 19'sd65536 - signed'({2'b0, st_q});
    wdiff  = signed'({2'b0, en_q}) - signed'({2'b0, st_q});
    num    = 41'(pa_q) - 41'(pb_q);
    full_v = {1'b0, d_q, 16'b0};
    trial  = 37'({d_q, 13'b0}) << bit_q;
    per    = quo_q + 4'd1;
    if (zero_q) lvl = 1'b0;
    else if (per < 4'd2) lvl = 1'b1;
    else lvl = rmod_q[per] == 4'd0;
  end

  assign rpush     = (state_q == S_IDLE && cmd_valid_i && rcnt_q != 2'd2 &&
                      cmd_i.kind != K_TICK) || state_q == S_FIN;
  assign cmd_pop_o = state_q == S_IDLE && cmd_valid_i && rcnt_q != 2'd2;

  // result beat being queued
  always_comb begin
    rdat.init_cmd    = 1'b0;
    rdat.drive_cmd   = DRV_NONE;
    rdat.motor_level = level_q;
    rdat.motor_ready = ready_q;
    if (state_q == S_FIN) begin
      rdat.init_cmd    = init_q;
      rdat.motor_level = lvl;
      if (lvl != level_q && ready_q) begin
        rdat.drive_cmd   = lvl ? DRV_START : DRV_STOP;
        rdat.motor_ready = dok_q;
      end
    end else if (cmd_i.kind == K_TIME) begin
      rdat.motor_ready = ready_q;
    end
  end

  // execution sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fc_q    <= '0;
      r60_q   <= '0;
      for (int k = 2; k <= 9; k++) rmod_q[k] <= '0;
      level_q <= 1'b0;
      ready_q <= 1'b0;
      dur_q   <= '0;
      el_q    <= '0;
      st_q    <= '0;
      en_q    <= '0;
      init_q  <= 1'b0;
      zero_q  <= 1'b0;
      dok_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.kind)
              K_TIME: el_q <= (tsum < {1'b0, dur_q}) ? tsum[19:0] : dur_q;
              K_REQ: begin
                if (!keep) begin
                  dur_q <= cmd_i.duration;
                  el_q  <= '0;
                  st_q  <= cmd_i.start_strength;
                  en_q  <= cmd_i.end_strength;
                end
              end
              K_TICK: begin
                fc_q   <= fc_q + 32'd1;
                dok_q  <= cmd_i.drive_ok;
                zero_q <= el_q == dur_q;
                // residues of the frame count; all restart when it wraps
                for (int k = 2; k <= 9; k++) begin
                  if (wrap || rmod_q[k] == 4'(k - 1)) rmod_q[k] <= '0;
                  else rmod_q[k] <= rmod_q[k] + 4'd1;
                end
                if (wrap || r60_q == RetryW'(RetryTicks - 1)) begin
                  r60_q <= '0;
                end else begin
                  r60_q <= r60_q + RetryW'(1);
                end
                // init retry when the count lands on a multiple
                if (!ready_q && (wrap || r60_q == RetryW'(RetryTicks - 1))) begin
                  init_q  <= 1'b1;
                  ready_q <= cmd_i.init_ok;
                end else begin
                  init_q  <= 1'b0;
                end
                state_q <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: state_q <= S_SUB;
        S_SUB: state_q <= S_DIV;
        S_DIV: if (bit_q == 2'd0) state_q <= S_FIN;
        S_FIN: begin
          level_q <= lvl;
          ready_q <= rdat.motor_ready;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath for the period: products, clamp, four-step restoring divide
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MUL: begin
        d_q  <= dsel;
        pa_q <= 40'(wa * signed'({1'b0, dsel}));
        pb_q <= 40'(wdiff * signed'({1'b0, esel}));
      end
      S_SUB: begin
        if (num < 0) rem_q <= '0;
        else if (num > signed'({4'b0, full_v})) rem_q <= full_v;
        else rem_q <= num[36:0];
        quo_q <= '0;
        bit_q <= 2'd3;
      end
      S_DIV: begin
        if (rem_q >= trial) begin
          rem_q        <= rem_q - trial;
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 2'd1;
      end
      default: ;
    endcase
  end

  // result queue
  assign empty = rcnt_q == 2'd0;
  assign res_o = rmem_q[rrd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (rpush) rwr_q <= !rwr_q;
      if (pop && !empty) rrd_q <= !rrd_q;
      rcnt_q <= rcnt_q + 2'(rpush) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpush) rmem_q[rwr_q] <= rdat;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rumble envelope pulse driver: a predictor of
// envelope, pulse period and motor link state checks every result beat.
// ----------------------------------------------------------------------------
module tb;
  import repd_pkg::*;

  // opcode with no function
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic       init_cmd;
    logic [1:0] drive_cmd;
    logic       level;
    logic       ready;
  } motor_res_t;

  // scoreboard: own copy of the driver state and the expected result queue
  class rumble_scoreboard;
    bit          pak;
    bit [31:0]   frames;
    bit          level_on;
    bit          link_ok;
    bit [19:0]   dur;
    bit [19:0]   elapsed;
    bit [16:0]   s_start;
    bit [16:0]   s_end;
    motor_res_t  pending_q[$];
    int          mismatches;
    int          checked;

    function void clear();
      pak = 0; frames = 0; level_on = 0; link_ok = 0;
      dur = 0; elapsed = 0; s_start = 0; s_end = 0;
      pending_q.delete();
      mismatches = 0; checked = 0;
    endfunction

    // pulse period 1..9 from the clamped interpolated strength
    function int unsigned period_of();
      longint d, e, num, full_scale;
      d = dur; e = elapsed;
      if (d == 0) begin
        d = 1; e = 0;
      end
      num = (65536 - longint'(s_start)) * d - (longint'(s_end) - longint'(s_start)) * e;
      full_scale = 65536 * d;
      if (num < 0) num = 0;
      if (num > full_scale) num = full_scale;
      return int'(num / (8192 * d)) + 1;
    endfunction

    function void note_item(logic [1:0] op, logic [15:0] dt, logic [16:0] s0,
                            logic [16:0] s1, logic [19:0] du, logic sup,
                            logic iok, logic dok);
      motor_res_t r;
      bit [20:0] sum_t;
      bit [19:0] left;
      bit prev, lvl;
      int unsigned p;
      r.init_cmd = 0; r.drive_cmd = DRV_NONE;
      case (op)
        OP_TIME: begin
          if (pak) begin
            sum_t = elapsed + dt;
            elapsed = (sum_t < dur) ? sum_t[19:0] : dur;
          end
        end
        OP_TICK: begin
          prev = level_on;
          frames++;
          if (!link_ok && frames % RetryTicks == 0) begin
            r.init_cmd = 1; link_ok = iok;
          end
          if (elapsed != dur) begin
            p = period_of();
            lvl = (p < 2) ? 1 : (frames % p == 0);
          end else lvl = 0;
          level_on = lvl;
          if (lvl != prev && link_ok) begin
            r.drive_cmd = lvl ? DRV_START : DRV_STOP;
            link_ok = dok;
          end
        end
        OP_REQ: begin
          if (du != 0 && pak && !sup) begin
            left = (dur >= elapsed) ? dur - elapsed : 0;
            if (!((left >= MinLeft) && (18'(s0) + s1 < 18'(s_start) + s_end))) begin
              dur = du; elapsed = 0; s_start = s0; s_end = s1;
            end
          end
        end
        default: ;
      endcase
      r.level = level_on; r.ready = link_ok;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic ic, logic [1:0] dc, logic lv, logic rd);
      motor_res_t x;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
        return;
      end
      x = pending_q.pop_front();
      if (ic !== x.init_cmd || dc !== x.drive_cmd || lv !== x.level || rd !== x.ready) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch beat %0d: exp init %0b drive %0d lvl %0b rdy %0b, got %0b %0d %0b %0b",
                   checked, x.init_cmd, x.drive_cmd, x.level, x.ready, ic, dc, lv, rd);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        push, full, cfg_valid, cfg_ready, cfg_data_i, empty, pop;
  logic [1:0]  opcode_i;
  logic [15:0] delta_time_i;
  logic [16:0] start_strength_i, end_strength_i;
  logic [19:0] duration_i;
  logic        suppress_i, init_ok_i, drive_ok_i;
  logic        init_cmd_o, motor_level_o, motor_ready_o;
  logic [1:0]  drive_cmd_o;

  rumble_scoreboard sb;
  bit no_stall;
  int n_ticks, n_req, n_starts;

  rumble_envelope_pulse_driver_unit uut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // one input beat with random gap before it; push stays high for a
  // back to back beat and is dropped only while idling
  task automatic send_item(logic [1:0] op, logic [15:0] dt, logic [16:0] s0,
                           logic [16:0] s1, logic [19:0] du, logic sup,
                           logic iok, logic dok);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      push <= 0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1; opcode_i <= op; delta_time_i <= dt; start_strength_i <= s0;
    end_strength_i <= s1; duration_i <= du; suppress_i <= sup;
    init_ok_i <= iok; drive_ok_i <= dok;
    do @(posedge clk_i); while (full);
    sb.note_item(op, dt, s0, s1, du, sup, iok, dok);
    if (op == OP_TICK) n_ticks++;
    if (op == OP_REQ) n_req++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_pak(bit v);
    cfg_valid <= 1; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.pak = v;
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  // random item, mostly well-formed envelopes and ticks
  task automatic random_item();
    int sel;
    logic [16:0] s0, s1;
    logic [19:0] du;
    sel = $urandom_range(0, 99);
    s0 = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    s1 = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    du = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 200000));
    if (sel < 60)
      send_item(OP_TICK, 16'($urandom), s0, s1, du, $urandom_range(0, 1),
                $urandom_range(0, 3) != 0, $urandom_range(0, 7) != 0);
    else if (sel < 80)
      send_item(OP_TIME, ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000))),
                s0, s1, du, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    else if (sel < 97)
      send_item(OP_REQ, 16'($urandom), s0, s1, du, $urandom_range(0, 5) == 0,
                $urandom_range(0, 1), $urandom_range(0, 1));
    else
      send_item(OpUnused, 16'($urandom), s0, s1, du, $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // result side: random pop stalls, sampling at the rising edge
  initial begin
    int gap;
    pop = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_stall ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        pop <= 0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1;
      do @(posedge clk_i); while (empty);
      sb.check_result(init_cmd_o, drive_cmd_o, motor_level_o, motor_ready_o);
      if (drive_cmd_o == DRV_START) n_starts++;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 0; push = 0; cfg_valid = 0; cfg_data_i = 0;
    opcode_i = OP_TIME; delta_time_i = 0; start_strength_i = 0; end_strength_i = 0;
    duration_i = 0; suppress_i = 0; init_ok_i = 0; drive_ok_i = 0;
    no_stall = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // accessory absent: requests and time ignored, ticks still run
    send_item(OP_REQ, 0, 17'd65536, 17'd65536, 20'd70000, 0, 0, 0);
    send_item(OP_TIME, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 1, 1);
    wait_drained();
    write_pak(1);
    // extremes, suppress, zero duration, out of range strength, unused opcode
    send_item(OP_REQ, 0, 17'd65536, 17'd0, 20'hFFFFF, 1, 0, 0);
    send_item(OP_REQ, 0, 17'd65536, 17'd0, 20'd0, 0, 0, 0);
    send_item(OP_REQ, 0, 17'h1FFFF, 17'h1FFFF, 20'hFFFFF, 0, 0, 0);
    send_item(OP_REQ, 0, 17'd0, 17'd0, 20'd100, 0, 0, 0);     // weaker, long left: kept out
    send_item(OP_TIME, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 1, 1);
    send_item(OpUnused, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 20'hFFFFF, 1, 1, 1);
    // sixty-two ticks so the link init fires, after a request that rises to full strength
    no_stall = 1;
    send_item(OP_REQ, 0, 17'd0, 17'd65536, 20'd1, 0, 0, 0);
    no_stall = 0;
    repeat (62) send_item(OP_TICK, 0, 0, 0, 0, 0, 1, 1);
    send_item(OP_TIME, 16'd1, 0, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 1, 0);

    // random phases with configuration changes between them
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_pak(ph != 3);
      if (ph == 5) no_stall = 1;
      repeat (250) random_item();
      no_stall = 0;
    end
    wait_drained();
    write_pak(0);
    repeat (20) random_item();
    wait_drained();
    $display("covered %0d ticks, %0d requests, %0d start commands, %0d results checked",
             n_ticks, n_req, n_starts, sb.checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
